// ----- rtl/wsd_pkg.sv -----
package wsd_pkg;

    localparam int unsigned CAP_W = 32;
    localparam logic [CAP_W-1:0] DEFAULT_MAX_PAYLOAD = 32'h0400_0000;
    localparam int unsigned DEFAULT_QUEUE_DEPTH = 4;

    localparam logic [6:0] LEN_16BIT = 7'd126;
    localparam logic [6:0] LEN_64BIT = 7'd127;
    localparam logic [6:0] CONTROL_MAX = 7'd125;

    localparam logic [3:0] OP_CONT = 4'h0;
    localparam logic [3:0] OP_CLOSE = 4'h8;
    localparam logic [3:0] OP_PING = 4'h9;
    localparam logic [3:0] OP_PONG = 4'hA;

    localparam logic [1:0] ERR_NONE = 2'd0;
    localparam logic [1:0] ERR_FRAME_LONG = 2'd1;
    localparam logic [1:0] ERR_BAD_CONTROL = 2'd2;
    localparam logic [1:0] ERR_MSG_LONG = 2'd3;

    typedef struct packed {
        logic [7:0] data;
        logic [7:0] key;
        logic       has_byte;
        logic [3:0] frame_opcode;
        logic       frame_fin;
        logic       frame_end;
        logic       message_end;
        logic [3:0] message_opcode;
        logic [1:0] error_code;
    } res_t;

    function automatic logic is_data_op(input logic [3:0] op);
        return (op != OP_CLOSE) && (op != OP_PING) && (op != OP_PONG);
    endfunction

endpackage

// ----- rtl/wsd_if.sv -----
interface wsd_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;

    modport source (output valid, output in_byte, input ready);
    modport sink (input valid, input in_byte, output ready);
endinterface

interface wsd_result_if;
    logic       valid;
    logic       ready;
    logic [7:0] payload_byte;
    logic       has_byte;
    logic [3:0] frame_opcode;
    logic       frame_fin;
    logic       frame_end;
    logic       message_end;
    logic [3:0] message_opcode;
    logic [1:0] error_code;

    modport source (
        output valid, output payload_byte, output has_byte, output frame_opcode,
        output frame_fin, output frame_end, output message_end,
        output message_opcode, output error_code, input ready
    );
    modport sink (
        input valid, input payload_byte, input has_byte, input frame_opcode,
        input frame_fin, input frame_end, input message_end,
        input message_opcode, input error_code, output ready
    );
endinterface

// ----- rtl/wsd_front.sv -----
module wsd_front (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_wr_en,
    input  logic [wsd_pkg::CAP_W-1:0]   cfg_wr_data,
    wsd_byte_if.sink                    in_ch,
    input  logic                        q_full,
    output logic                        push,
    output wsd_pkg::res_t               push_rec,
    output logic                        err_latched
);
    import wsd_pkg::*;

    typedef enum logic [4:0] {
        PH_BYTE0   = 5'b00001,
        PH_BYTE1   = 5'b00010,
        PH_EXTLEN  = 5'b00100,
        PH_MASKKEY = 5'b01000,
        PH_PAYLOAD = 5'b10000
    } phase_t;

    phase_t      phase_reg, phase_next;
    logic [2:0]  idx_reg, idx_next;
    logic [63:0] dlen_reg, dlen_next;
    logic [31:0] key_reg, key_next;
    logic        mask_reg, mask_next;
    logic        fin_reg, fin_next;
    logic [3:0]  op_reg, op_next;
    logic [1:0]  pos_reg, pos_next;
    logic [31:0] remain_reg, remain_next;
    logic [31:0] msg_bytes_reg, msg_bytes_next;
    logic        msg_open_reg, msg_open_next;
    logic [3:0]  msg_op_reg, msg_op_next;
    logic        err_reg, err_next;
    logic [CAP_W-1:0] max_reg;

    logic        accept;
    logic [7:0]  b;
    logic        len_done, key_done, fd;
    logic [7:0]  fd_data, fd_key;
    logic        fd_has;
    logic        too_long, bad_ctrl, too_msg;
    logic [32:0] msg_sum;
    logic [7:0]  kbyte;
    logic [1:0]  err_code;

    assign in_ch.ready = !q_full;
    assign accept = in_ch.valid && !q_full;
    assign b = in_ch.in_byte;
    assign err_latched = err_reg;

    always_comb
    begin
        case (pos_reg)
            2'd0:    kbyte = key_reg[31:24];
            2'd1:    kbyte = key_reg[23:16];
            2'd2:    kbyte = key_reg[15:8];
            default: kbyte = key_reg[7:0];
        endcase
        if (!mask_reg)
        begin
            kbyte = 8'h00;
        end
    end

    always_comb
    begin
        phase_next     = phase_reg;
        idx_next       = idx_reg;
        dlen_next      = dlen_reg;
        key_next       = key_reg;
        mask_next      = mask_reg;
        fin_next       = fin_reg;
        op_next        = op_reg;
        pos_next       = pos_reg;
        remain_next    = remain_reg;
        msg_bytes_next = msg_bytes_reg;
        msg_open_next  = msg_open_reg;
        msg_op_next    = msg_op_reg;
        err_next       = err_reg;
        push           = 1'b0;
        push_rec       = '0;
        len_done       = 1'b0;
        key_done       = 1'b0;
        fd             = 1'b0;
        fd_data        = 8'h00;
        fd_key         = 8'h00;
        fd_has         = 1'b0;
        err_code       = ERR_NONE;
        too_long       = 1'b0;
        bad_ctrl       = 1'b0;
        too_msg        = 1'b0;
        msg_sum        = '0;

        if (accept && !err_reg)
        begin
            case (phase_reg)
                PH_BYTE0:
                begin
                    fin_next   = b[7];
                    op_next    = b[3:0];
                    phase_next = PH_BYTE1;
                end
                PH_BYTE1:
                begin
                    mask_next = b[7];
                    dlen_next = '0;
                    if (b[6:0] == LEN_16BIT)
                    begin
                        phase_next = PH_EXTLEN;
                        idx_next   = 3'd1;
                    end
                    else if (b[6:0] == LEN_64BIT)
                    begin
                        phase_next = PH_EXTLEN;
                        idx_next   = 3'd7;
                    end
                    else
                    begin
                        dlen_next = {57'd0, b[6:0]};
                        len_done  = 1'b1;
                    end
                end
                PH_EXTLEN:
                begin
                    dlen_next = {dlen_reg[55:0], b};
                    if (idx_reg == 3'd0)
                    begin
                        len_done = 1'b1;
                    end
                    else
                    begin
                        idx_next = idx_reg - 3'd1;
                    end
                end
                PH_MASKKEY:
                begin
                    key_next = {key_reg[23:0], b};
                    if (idx_reg == 3'd0)
                    begin
                        key_done = 1'b1;
                    end
                    else
                    begin
                        idx_next = idx_reg - 3'd1;
                    end
                end
                PH_PAYLOAD:
                begin
                    if (remain_reg[31:1] == 31'd0)
                    begin
                        fd      = 1'b1;
                        fd_data = b;
                        fd_key  = kbyte;
                        fd_has  = 1'b1;
                    end
                    else
                    begin
                        pos_next    = pos_reg + 2'd1;
                        remain_next = remain_reg - 32'd1;
                        push        = 1'b1;
                        push_rec.data           = b;
                        push_rec.key            = kbyte;
                        push_rec.has_byte       = 1'b1;
                        push_rec.frame_opcode   = op_reg;
                        push_rec.frame_fin      = fin_reg;
                        push_rec.message_opcode = msg_open_reg ? msg_op_reg : 4'h0;
                    end
                end
                default:
                begin
                    phase_next = PH_BYTE0;
                end
            endcase

            if (len_done)
            begin
                too_long = (|dlen_next[63:32]) || (dlen_next[31:0] > max_reg);
                bad_ctrl = op_next[3] &&
                           ((|dlen_next[63:7]) || (dlen_next[6:0] > CONTROL_MAX) || !fin_next);
                msg_sum  = {1'b0, msg_bytes_reg} + {1'b0, dlen_next[31:0]};
                too_msg  = msg_sum > {1'b0, max_reg};
                if (too_long)
                begin
                    err_code = ERR_FRAME_LONG;
                end
                else if (bad_ctrl)
                begin
                    err_code = ERR_BAD_CONTROL;
                end
                else if ((op_next == OP_CONT) && too_msg)
                begin
                    err_code = ERR_MSG_LONG;
                end
                else
                begin
                    if (op_next == OP_CONT)
                    begin
                        msg_bytes_next = msg_sum[31:0];
                    end
                    else if (is_data_op(op_next))
                    begin
                        msg_bytes_next = dlen_next[31:0];
                        msg_open_next  = 1'b1;
                        msg_op_next    = op_next;
                    end
                    remain_next = dlen_next[31:0];
                    if (mask_next)
                    begin
                        phase_next = PH_MASKKEY;
                        idx_next   = 3'd3;
                        key_next   = '0;
                    end
                    else
                    begin
                        key_done = 1'b1;
                    end
                end
            end

            if (err_code != ERR_NONE)
            begin
                err_next = 1'b1;
                push     = 1'b1;
                push_rec.frame_opcode = op_next;
                push_rec.frame_fin    = fin_next;
                push_rec.error_code   = err_code;
            end

            if (key_done)
            begin
                pos_next = 2'd0;
                if (remain_next == 32'd0)
                begin
                    fd = 1'b1;
                end
                else
                begin
                    phase_next = PH_PAYLOAD;
                end
            end

            if (fd)
            begin
                push = 1'b1;
                push_rec.data           = fd_data;
                push_rec.key            = fd_key;
                push_rec.has_byte       = fd_has;
                push_rec.frame_opcode   = op_next;
                push_rec.frame_fin      = fin_next;
                push_rec.frame_end      = 1'b1;
                push_rec.message_opcode = msg_open_next ? msg_op_next : 4'h0;
                if (is_data_op(op_next) && fin_next && msg_open_next)
                begin
                    push_rec.message_end = 1'b1;
                    msg_open_next        = 1'b0;
                    msg_bytes_next       = '0;
                end
                phase_next = PH_BYTE0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_BYTE0;
            idx_reg       <= '0;
            dlen_reg      <= '0;
            key_reg       <= '0;
            mask_reg      <= 1'b0;
            fin_reg       <= 1'b0;
            op_reg        <= '0;
            pos_reg       <= '0;
            remain_reg    <= '0;
            msg_bytes_reg <= '0;
            msg_open_reg  <= 1'b0;
            msg_op_reg    <= '0;
            err_reg       <= 1'b0;
            max_reg       <= DEFAULT_MAX_PAYLOAD;
        end
        else
        begin
            phase_reg     <= phase_next;
            idx_reg       <= idx_next;
            dlen_reg      <= dlen_next;
            key_reg       <= key_next;
            mask_reg      <= mask_next;
            fin_reg       <= fin_next;
            op_reg        <= op_next;
            pos_reg       <= pos_next;
            remain_reg    <= remain_next;
            msg_bytes_reg <= msg_bytes_next;
            msg_open_reg  <= msg_open_next;
            msg_op_reg    <= msg_op_next;
            err_reg       <= err_next;
            if (cfg_wr_en)
            begin
                max_reg <= cfg_wr_data;
            end
        end
    end

endmodule

// ----- rtl/wsd_queue.sv -----
module wsd_queue #(
    parameter int unsigned DEPTH = wsd_pkg::DEFAULT_QUEUE_DEPTH
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  wsd_pkg::res_t  push_rec,
    input  logic           pop,
    output wsd_pkg::res_t  head_rec,
    output logic           full,
    output logic           empty
);
    import wsd_pkg::*;

    localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CntW = $clog2(DEPTH + 1);
    localparam logic [PtrW-1:0] LastPtr = PtrW'(DEPTH - 1);

    res_t            mem [DEPTH];
    logic [PtrW-1:0] head_reg, head_next;
    logic [PtrW-1:0] tail_reg, tail_next;
    logic [CntW-1:0] count_reg, count_next;

    assign full     = (count_reg == CntW'(DEPTH));
    assign empty    = (count_reg == '0);
    assign head_rec = mem[head_reg];

    always_comb
    begin
        head_next  = head_reg;
        tail_next  = tail_reg;
        count_next = count_reg;
        if (push)
        begin
            tail_next = (tail_reg == LastPtr) ? '0 : tail_reg + PtrW'(1);
        end
        if (pop)
        begin
            head_next = (head_reg == LastPtr) ? '0 : head_reg + PtrW'(1);
        end
        case ({push, pop})
            2'b10:   count_next = count_reg + CntW'(1);
            2'b01:   count_next = count_reg - CntW'(1);
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[tail_reg] <= push_rec;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
        end
    end

endmodule

// ----- rtl/wsd_back.sv -----
module wsd_back (
    input  logic           clk,
    input  logic           rst_n,
    input  wsd_pkg::res_t  head_rec,
    input  logic           q_empty,
    output logic           pop,
    wsd_result_if.source   out_ch
);
    import wsd_pkg::*;

    logic       valid_reg;
    res_t       rec_reg;
    logic [7:0] byte_reg;

    assign pop = !q_empty && (!valid_reg || out_ch.ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (pop)
        begin
            valid_reg <= 1'b1;
        end
        else if (out_ch.ready)
        begin
            valid_reg <= 1'b0;
        end
    end

    // unmask on the way out
    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            rec_reg  <= head_rec;
            byte_reg <= head_rec.data ^ head_rec.key;
        end
    end

    assign out_ch.valid          = valid_reg;
    assign out_ch.payload_byte   = byte_reg;
    assign out_ch.has_byte       = rec_reg.has_byte;
    assign out_ch.frame_opcode   = rec_reg.frame_opcode;
    assign out_ch.frame_fin      = rec_reg.frame_fin;
    assign out_ch.frame_end      = rec_reg.frame_end;
    assign out_ch.message_end    = rec_reg.message_end;
    assign out_ch.message_opcode = rec_reg.message_opcode;
    assign out_ch.error_code     = rec_reg.error_code;

endmodule

// ----- rtl/websocket_frame_deframer.sv -----
// results are queued, then registered at the output; one byte per cycle while
// the queue has room; header and mask key bytes yield only error or empty-frame
// results; QUEUE_DEPTH queue entries let the parser run while the output stalls
// reset clears the parser, message tracking and error latch; cap returns to 64 MiB
// after an error result the block takes bytes but stays silent until reset
module websocket_frame_deframer #(
    parameter int unsigned QUEUE_DEPTH = wsd_pkg::DEFAULT_QUEUE_DEPTH
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_wr_en,
    input  logic [wsd_pkg::CAP_W-1:0]   cfg_wr_data,
    wsd_byte_if.sink                    in_ch,
    wsd_result_if.source                out_ch
);
    import wsd_pkg::*;

    logic push, pop, q_full, q_empty, err_latched;
    res_t push_rec, head_rec;

    wsd_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_ch       (in_ch),
        .q_full      (q_full),
        .push        (push),
        .push_rec    (push_rec),
        .err_latched (err_latched)
    );

    wsd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_rec (push_rec),
        .pop      (pop),
        .head_rec (head_rec),
        .full     (q_full),
        .empty    (q_empty)
    );

    wsd_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .head_rec (head_rec),
        .q_empty  (q_empty),
        .pop      (pop),
        .out_ch   (out_ch)
    );

    a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !q_full)
        else $error("push into full queue");

    a_silent_after_error: assert property (@(posedge clk) disable iff (!rst_n)
        err_latched |-> !push)
        else $error("result produced after error");

    a_msg_end_on_frame_end: assert property (@(posedge clk) disable iff (!rst_n)
        (out_ch.valid && out_ch.message_end) |-> out_ch.frame_end)
        else $error("message end without frame end");

    a_error_no_byte: assert property (@(posedge clk) disable iff (!rst_n)
        (out_ch.valid && (out_ch.error_code != ERR_NONE)) |->
            (!out_ch.has_byte && !out_ch.frame_end))
        else $error("error result carries data");

endmodule
